// ----- src/qmac_pkg.sv -----
package qmac_pkg;

   // byte lanes in the SIMD multiply-accumulate
   localparam int LANES = 4;
   // lanes at index 4 and up see zero bytes, so the operands are padded out
   localparam int PadBits = ((LANES > 4) ? LANES : 4) * 8;

   localparam logic signed [9:0] OffsetPos = 10'sd128;
   localparam logic signed [9:0] OffsetNeg = -10'sd83;
   localparam logic signed [33:0] OutBias = 34'sd128;
   localparam logic signed [33:0] OutMax = 34'sd127;
   localparam logic signed [33:0] OutMin = -34'sd128;
   localparam logic [63:0] LoadNudge = 64'h0000_0000_4000_0000;

   typedef enum logic [1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_MAC     = 2'd1,
      REQ_LOAD    = 2'd2,
      REQ_REQUANT = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type kind;
      logic         simd_mode;
      logic         offset_select;
      logic [31:0]  operand_a;
      logic [31:0]  operand_b;
   } request_type;

endpackage

// ----- src/qmac_mac.sv -----
module qmac_mac import qmac_pkg::*; (
   input  logic [31:0] acc,
   input  logic        simd_mode,
   input  logic        offset_select,
   input  logic [31:0] operand_a,
   input  logic [31:0] operand_b,
   output logic [31:0] acc_next
);

   logic [PadBits-1:0] pad_a;
   logic [PadBits-1:0] pad_b;
   logic signed [9:0]  offset;
   logic signed [9:0]  lane_a [LANES];
   logic signed [7:0]  lane_b [LANES];
   logic signed [17:0] prod [LANES];

   assign pad_a  = PadBits'(operand_a);
   assign pad_b  = PadBits'(operand_b);
   assign offset = offset_select ? OffsetNeg : OffsetPos;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_a[i] = signed'({{2{pad_a[i*8+7]}}, pad_a[i*8 +: 8]}) + offset;
         lane_b[i] = signed'(pad_b[i*8 +: 8]);
         prod[i]   = lane_a[i] * lane_b[i];
      end
   end

   always_comb begin
      acc_next = acc;
      for (int i = 0; i < LANES; i++) begin
         if (i == 0 || simd_mode) begin
            acc_next = acc_next + 32'(prod[i]);
         end
      end
   end

endmodule

// ----- src/qmac_load.sv -----
module qmac_load import qmac_pkg::*; (
   input  logic [31:0] operand_a,
   input  logic [31:0] operand_b,
   output logic [31:0] acc_next
);

   logic        neg;
   logic [63:0] mag;
   logic [63:0] sum;
   logic [31:0] quot;

   // negative product: |P| + 2^30 - 1 equals ~P + 2^30
   assign neg  = operand_a[31];
   assign mag  = neg ? ~{operand_a, operand_b} : {operand_a, operand_b};
   assign sum  = mag + LoadNudge;
   assign quot = sum[62:31];
   assign acc_next = neg ? (32'd0 - quot) : quot;

endmodule

// ----- src/qmac_requant.sv -----
module qmac_requant import qmac_pkg::*; (
   input  logic [31:0] acc,
   input  logic [31:0] operand_b,
   output logic [31:0] acc_next
);

   logic               neg;
   logic [31:0]        expo;
   logic [4:0]         shamt;
   logic [31:0]        mask;
   logic [31:0]        rem;
   logic [31:0]        thr;
   logic signed [31:0] shifted;
   logic signed [33:0] val;

   assign neg  = acc[31];
   assign expo = 32'd0 - operand_b;

   always_comb begin
      if (expo == 32'd0 || expo[31]) begin
         shamt = 5'd0;
      end else if (expo > 32'd31) begin
         shamt = 5'd31;
      end else begin
         shamt = expo[4:0];
      end
   end

   assign mask    = (32'd1 << shamt) - 32'd1;
   assign rem     = acc & mask;
   assign thr     = (mask >> 1) + {31'd0, neg};
   assign shifted = signed'(acc) >>> shamt;
   assign val     = 34'(shifted) + signed'({33'd0, rem > thr}) - OutBias;

   always_comb begin
      if (val > OutMax) begin
         acc_next = 32'(OutMax);
      end else if (val < OutMin) begin
         acc_next = 32'(OutMin);
      end else begin
         acc_next = val[31:0];
      end
   end

endmodule

// ----- src/quantized_mac_requant_unit.sv -----
// Quantized MAC and requantize unit with one 32-bit accumulator.
// Request channel (req_*): tdata carries operand_a and operand_b, tuser the
// request kind (clear, multiply-accumulate, rounding high-mul load,
// requantize) plus the SIMD and input-offset flags.
// Response channel (rsp_*): one response per request, holding the
// accumulator value after that request.
// A request is captured in the input register, worked out when it moves on
// and shows on rsp_tdata from the accumulator register. Throughput is one
// request per cycle while rsp_tready stays high: the accumulator is read
// and rewritten in the single cycle that moves a request from the input
// register to the output register.
// When rsp_tready is low, the response holds, the input register fills and
// then req_tready drops; no request is lost or repeated.
// Reset (synchronous, active high) clears the accumulator and both valid
// flags; the block takes requests in the first cycle after reset.
module quantized_mac_requant_unit import qmac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // operand_a [31:0], operand_b [63:32]
   input  logic [3:0]  req_tuser,  // req_type [1:0], simd_mode [2], offset_select [3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // result [31:0]
);

   logic        in_valid_ff, in_valid_in;
   request_type in_req_ff;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] acc_ff, acc_in;
   logic        advance;
   logic [31:0] mac_acc, load_acc, requant_acc;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = acc_ff;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   qmac_mac u_mac (
      .acc           (acc_ff),
      .simd_mode     (in_req_ff.simd_mode),
      .offset_select (in_req_ff.offset_select),
      .operand_a     (in_req_ff.operand_a),
      .operand_b     (in_req_ff.operand_b),
      .acc_next      (mac_acc)
   );

   qmac_load u_load (
      .operand_a (in_req_ff.operand_a),
      .operand_b (in_req_ff.operand_b),
      .acc_next  (load_acc)
   );

   qmac_requant u_requant (
      .acc       (acc_ff),
      .operand_b (in_req_ff.operand_b),
      .acc_next  (requant_acc)
   );

   always_comb begin
      acc_in = acc_ff;
      if (advance) begin
         case (in_req_ff.kind)
            REQ_CLEAR:   acc_in = 32'd0;
            REQ_MAC:     acc_in = mac_acc;
            REQ_LOAD:    acc_in = load_acc;
            REQ_REQUANT: acc_in = requant_acc;
            default:     acc_in = 32'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= 32'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_req_ff.kind          <= req_kind_type'(req_tuser[1:0]);
         in_req_ff.simd_mode     <= req_tuser[2];
         in_req_ff.offset_select <= req_tuser[3];
         in_req_ff.operand_a     <= req_tdata[31:0];
         in_req_ff.operand_b     <= req_tdata[63:32];
      end
   end

   // accumulator only moves together with a new response
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(acc_ff))
      else $error("accumulator changed without a request");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      advance && in_req_ff.kind == REQ_CLEAR |=> acc_ff == 32'd0 && rsp_tvalid)
      else $error("clear did not zero the accumulator");

   a_requant_range: assert property (@(posedge clock) disable iff (reset)
      advance && in_req_ff.kind == REQ_REQUANT |=>
         rsp_tdata[31:7] == 25'd0 || rsp_tdata[31:7] == 25'h1ff_ffff)
      else $error("requantize result outside int8 range");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_req_ff))
      else $error("stalled request dropped or changed");

endmodule

// ----- tb/quantized_mac_requant_unit_test.sv -----
module quantized_mac_requant_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import qmac_pkg::*;

   localparam int RandomRequests = 800;
   localparam int CycleLimit = 200000;
   localparam int DrainCycles = 12;
   localparam int CalmTail = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // operand_a [31:0], operand_b [63:32]
   logic [3:0]  req_tuser = '0;   // req_type [1:0], simd_mode [2], offset_select [3]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // result [31:0]

   quantized_mac_requant_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   request_type pending_reqs[$];
   logic [31:0] acc_due[$];
   logic [31:0] acc_shadow = '0;
   request_type on_bus;
   int          total_reqs;
   int          reqs_sent;
   int          rsps_checked;
   int          error_count;
   int          cycle_count;
   int          kind_count[4];
   logic        calm_tail = 1'b0;

   // accumulator after one request, given the accumulator before it
   function automatic logic [31:0] acc_after(request_type r, logic [31:0] acc);
      int               lane_cnt;
      int               off;
      logic [63:0]      prod;
      logic [63:0]      mag;
      logic [63:0]      quo;
      logic [31:0]      e;
      int               s;
      logic [31:0]      mask;
      logic [31:0]      rem;
      logic [31:0]      thr;
      logic signed [31:0] shifted;
      longint           v;
      case (r.kind)
         REQ_MAC: begin
            lane_cnt = r.simd_mode ? LANES : 1;
            off = r.offset_select ? -83 : 128;
            for (int i = 0; i < lane_cnt; i++) begin
               // lanes past the 32-bit operand read zero bytes
               if (i < 4)
                  acc = acc + 32'((int'($signed(r.operand_a[8*i +: 8])) + off)
                                  * int'($signed(r.operand_b[8*i +: 8])));
            end
            return acc;
         end
         REQ_LOAD: begin
            prod = {r.operand_a, r.operand_b};
            if (!prod[63]) begin
               quo = (prod + 64'h0000_0000_4000_0000) >> 31;
               return quo[31:0];
            end
            // round the magnitude, ties toward zero
            mag = ~prod + 64'd1;
            quo = (mag + 64'h0000_0000_3fff_ffff) >> 31;
            return 32'd0 - quo[31:0];
         end
         REQ_REQUANT: begin
            e = 32'd0 - r.operand_b;
            if (e == 32'd0 || e[31])
               s = 0;
            else if (e > 32'd31)
               s = 31;
            else
               s = int'(e);
            mask = (s == 0) ? 32'd0 : ((32'd1 << s) - 32'd1);
            rem = acc & mask;
            thr = (mask >> 1) + {31'd0, acc[31]};
            shifted = $signed(acc) >>> s;
            v = longint'(shifted);
            if (rem > thr)
               v = v + 1;
            v = v - 128;
            if (v > 127)
               v = 127;
            if (v < -128)
               v = -128;
            return v[31:0];
         end
         default: begin
            return 32'd0;
         end
      endcase
   endfunction

   task automatic queue_req(req_kind_type kind, logic simd, logic offsel,
                            logic [31:0] a, logic [31:0] b);
      request_type r;
      r.kind = kind;
      r.simd_mode = simd;
      r.offset_select = offsel;
      r.operand_a = a;
      r.operand_b = b;
      pending_reqs.push_back(r);
   endtask

   // load whose rounded high half is exactly x
   task automatic queue_load_of(logic [31:0] x);
      logic [63:0] p;
      p = {{32{x[31]}}, x} << 31;
      queue_req(REQ_LOAD, 1'($urandom), 1'($urandom), p[63:32], p[31:0]);
   endtask

   task automatic queue_random_mac;
      logic [31:0] a;
      logic [31:0] b;
      a = $urandom;
      b = $urandom;
      // sometimes keep bytes at the lane extremes
      if ($urandom_range(0, 5) == 0)
         a = $urandom_range(0, 1) ? 32'h8080_8080 : 32'h7f7f_7f7f;
      if ($urandom_range(0, 5) == 0)
         b = $urandom_range(0, 1) ? 32'h8080_8080 : 32'h7f7f_7f7f;
      queue_req(REQ_MAC, 1'($urandom), 1'($urandom), a, b);
   endtask

   // driver
   int send_gap = 0;
   int send_window = 0;
   bit send_busy = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            acc_shadow = acc_after(on_bus, acc_shadow);
            acc_due.push_back(acc_shadow);
            kind_count[on_bus.kind]++;
            reqs_sent++;
         end
         if (send_window == 0) begin
            send_window = $urandom_range(20, 80);
            send_busy = $urandom_range(0, 2) != 0;
         end
         send_window--;
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               on_bus = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {on_bus.operand_b, on_bus.operand_a};
               req_tuser <= {on_bus.offset_select, on_bus.simd_mode, on_bus.kind};
               if (send_busy && !calm_tail && $urandom_range(0, 3) == 0)
                  send_gap = $urandom_range(1, 4);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         calm_tail <= pending_reqs.size() < CalmTail;
      end
   end

   // monitor
   int stall_left = 0;
   int recv_window = 0;
   bit recv_busy = 1'b0;

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (acc_due.size() == 0) begin
               $error("unexpected response: result %h", rsp_tdata);
               error_count++;
            end else begin
               want = acc_due.pop_front();
               rsps_checked++;
               if (rsp_tdata !== want) begin
                  $error("result mismatch: expected %h, actual %h", want, rsp_tdata);
                  error_count++;
               end
            end
         end
         if (recv_window == 0) begin
            recv_window = $urandom_range(20, 80);
            recv_busy = $urandom_range(0, 2) != 0;
         end
         recv_window--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (recv_busy && !calm_tail && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d requests sent", cycle_count, reqs_sent);
         $display("quantized_mac_requant_unit_test failed");
         $finish;
      end
   end

   initial begin
      int target;
      int n;
      logic [31:0] b;

      // directed: operand extremes, every request kind, load rounding and
      // sign handling, requantize shift clamping, rounding and saturation
      queue_req(REQ_CLEAR, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
      queue_req(REQ_MAC, 1'b1, 1'b0, 32'h8080_8080, 32'h8080_8080);
      queue_req(REQ_MAC, 1'b1, 1'b1, 32'h8080_8080, 32'h8080_8080);
      queue_req(REQ_MAC, 1'b1, 1'b0, 32'h7f7f_7f7f, 32'h7f7f_7f7f);
      queue_req(REQ_MAC, 1'b1, 1'b1, 32'h7f7f_7f7f, 32'h8080_8080);
      queue_req(REQ_MAC, 1'b0, 1'b0, 32'hffff_ff01, 32'h8080_8080);
      queue_req(REQ_MAC, 1'b0, 1'b1, 32'h0000_0000, 32'h7f7f_7f7f);
      queue_req(REQ_LOAD, 1'b0, 1'b0, 32'h7fff_ffff, 32'hffff_ffff);
      queue_req(REQ_LOAD, 1'b1, 1'b1, 32'h8000_0000, 32'h0000_0000);
      queue_req(REQ_LOAD, 1'b0, 1'b0, 32'hffff_ffff, 32'hffff_ffff);
      queue_req(REQ_LOAD, 1'b0, 1'b0, 32'h0000_0000, 32'h4000_0000);
      queue_req(REQ_LOAD, 1'b0, 1'b0, 32'hffff_ffff, 32'hc000_0000);
      queue_load_of(32'd1000);
      queue_req(REQ_REQUANT, 1'b1, 1'b0, 32'h0, 32'h0000_0000);
      queue_load_of(-32'sd1000);
      queue_req(REQ_REQUANT, 1'b0, 1'b1, 32'h0, 32'hffff_ffff);
      queue_load_of(32'd5);
      queue_req(REQ_REQUANT, 1'b0, 1'b0, 32'h0, 32'hffff_ffff);
      queue_load_of(32'h7fff_ffff);
      queue_req(REQ_REQUANT, 1'b0, 1'b0, 32'h0, 32'hffff_ffe1);
      queue_load_of(32'h8000_0000);
      queue_req(REQ_REQUANT, 1'b0, 1'b0, 32'h0, 32'hffff_ffe0);
      queue_req(REQ_REQUANT, 1'b0, 1'b0, 32'h0, 32'h8000_0000);
      queue_req(REQ_REQUANT, 1'b0, 1'b0, 32'h0, 32'hffff_ff00);
      queue_load_of(32'h7fff_fff0);
      queue_req(REQ_MAC, 1'b1, 1'b0, 32'h7f7f_7f7f, 32'h7f7f_7f7f);

      // random: mostly clear/load, a run of MACs, then usually requantize; some fully random requests
      target = pending_reqs.size() + RandomRequests;
      while (pending_reqs.size() < target) begin
         if ($urandom_range(0, 9) < 2) begin
            queue_req(req_kind_type'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                      $urandom, $urandom);
         end else begin
            case ($urandom_range(0, 3))
               0: queue_req(REQ_CLEAR, 1'($urandom), 1'($urandom), $urandom, $urandom);
               1: queue_req(REQ_LOAD, 1'($urandom), 1'($urandom), $urandom, $urandom);
               2: queue_load_of(32'($urandom_range(0, 60000)) - 32'd30000);
               default: ;   // keep accumulating on the current value
            endcase
            n = $urandom_range(1, 12);
            repeat (n) queue_random_mac();
            if ($urandom_range(0, 3) != 0) begin
               b = ($urandom_range(0, 7) == 0) ? 32'($urandom)
                                               : 32'd0 - 32'($urandom_range(0, 34));
               queue_req(REQ_REQUANT, 1'($urandom), 1'($urandom), $urandom, b);
            end
         end
      end
      total_reqs = pending_reqs.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (!(reqs_sent == total_reqs && acc_due.size() == 0))
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (acc_due.size() != 0) begin
         $error("%0d responses never arrived", acc_due.size());
         error_count++;
      end

      $display("%0d requests: %0d clear, %0d mac, %0d load, %0d requantize",
               reqs_sent, kind_count[REQ_CLEAR], kind_count[REQ_MAC],
               kind_count[REQ_LOAD], kind_count[REQ_REQUANT]);
      $display("%0d responses checked against the accumulator model, %0d errors",
               rsps_checked, error_count);
      if (error_count == 0)
         $display("quantized_mac_requant_unit_test passed");
      else
         $display("quantized_mac_requant_unit_test failed");
      $finish;
   end

endmodule

// ----- files.f -----
src/qmac_pkg.sv
src/qmac_mac.sv
src/qmac_load.sv
src/qmac_requant.sv
src/quantized_mac_requant_unit.sv
tb/quantized_mac_requant_unit_test.sv
